>>> sv/dnest_pkg.sv
// Shared types and constants of the depth image normal estimator.
// Holds the controller/datapath command codes and the status struct.
// No dependencies.
package dnest_pkg;

  typedef logic [4:0] dnest_op_t;

  localparam dnest_op_t OP_NONE   = 5'd0;
  localparam dnest_op_t OP_LOAD   = 5'd1;
  localparam dnest_op_t OP_DECIDE = 5'd2;
  localparam dnest_op_t OP_READ   = 5'd3;
  localparam dnest_op_t OP_MUL    = 5'd4;
  localparam dnest_op_t OP_ACC    = 5'd5;
  localparam dnest_op_t OP_MAG    = 5'd6;
  localparam dnest_op_t OP_NORM   = 5'd7;
  localparam dnest_op_t OP_SQ     = 5'd8;
  localparam dnest_op_t OP_SQACC  = 5'd9;
  localparam dnest_op_t OP_SQRTI  = 5'd10;
  localparam dnest_op_t OP_SQRT   = 5'd11;
  localparam dnest_op_t OP_DIVI   = 5'd12;
  localparam dnest_op_t OP_DIV    = 5'd13;
  localparam dnest_op_t OP_DIVE   = 5'd14;
  localparam dnest_op_t OP_DOT    = 5'd15;
  localparam dnest_op_t OP_DOTACC = 5'd16;
  localparam dnest_op_t OP_FLIP   = 5'd17;
  localparam dnest_op_t OP_OUT    = 5'd18;
  localparam dnest_op_t OP_UPD    = 5'd19;

  localparam logic [1:0] KIND_IGNORE = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_NORMAL = 2'd2;

  localparam int READ_STEPS = 5;   // four reads through a registered read port
  localparam int MUL_STEPS  = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 46;  // numerator bits
  localparam int FRAC_BITS  = 14;
  localparam logic [15:0] Q_ONE = 16'd16384;
  localparam logic [10:0] FW_RESET = 11'd640;

  typedef struct packed {
    dnest_op_t   op;
    logic [2:0]  idx;
  } dnest_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       degen;
    logic       norm_ok;
    logic       out_busy;
  } dnest_sts_t;

endpackage

>>> sv/dnest_if.sv
// Channel interfaces of the depth image normal estimator: input points,
// result normals and the frame width write port. Depends on nothing.
interface dnest_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  modport source (output valid, action, point_x, point_y, point_z, input ready);
  modport sink (input valid, action, point_x, point_y, point_z, output ready);
endinterface

interface dnest_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               degenerate;
  logic               frame_last;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, frame_last,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, frame_last,
                output ready);
endinterface

interface dnest_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> sv/depth_image_normal_estimator.sv
// Top level of the depth image normal estimator: channel wiring around
// dnest_ctrl and dnest_datapath. Uses dnest_pkg and the dnest_if interfaces.
//
// Usage: points enter on in_if in raster order (action 0), frame_width
// pixels per row, frame_width written on cfg_if while idle. Each pixel of
// the second and later rows yields the normal of the pixel above it on
// out_if; after the last pixel of a frame, one drain item (action 1) per
// column flushes the last row, the final one with frame_last set.
// Items are handled one at a time. A pixel of the first row is only stored,
// an ignored item is only decoded and a degenerate normal skips the square
// root and divisions; a full normal runs through the bit-serial square root
// (32 steps), the three bit-serial divisions (46 steps each, plus a load and
// an end step) and the shift normalisation of up to 29 single-bit steps.
// Results sit in an output register; while the receiver stalls the block
// finishes the item but waits before loading the next result.
// Reset (rst_n low, synchronous) sets frame_width to 640 and starts a
// new frame; no transfer is taken while it is held. The line store is not
// cleared and needs no clearing pass.
module depth_image_normal_estimator
  import dnest_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dnest_in_if.sink    in_if,
  dnest_out_if.source out_if,
  dnest_cfg_if.sink   cfg_if
);

  dnest_cmd_t cmd;
  dnest_sts_t sts;

  assign cfg_if.ready = rst_n;

  dnest_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dnest_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_if.action),
    .in_px     (in_if.point_x),
    .in_py     (in_if.point_y),
    .in_pz     (in_if.point_z),
    .cfg_we    (cfg_if.valid),
    .cfg_data  (cfg_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_nx    (out_if.normal_x),
    .out_ny    (out_if.normal_y),
    .out_nz    (out_if.normal_z),
    .out_degen (out_if.degenerate),
    .out_last  (out_if.frame_last)
  );

endmodule

>>> sv/dnest_datapath.sv
// Datapath: line store, frame position, cross product, normalisation,
// square root, division and flip. Driven by dnest_ctrl; uses dnest_pkg.
module dnest_datapath
  import dnest_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dnest_cmd_t                   cmd,
  output dnest_sts_t                   sts,
  input  logic                         in_action,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  input  logic                         cfg_we,
  input  logic [10:0]                  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           out_nx,
  output logic signed [15:0]           out_ny,
  output logic signed [15:0]           out_nz,
  output logic                         out_degen,
  output logic                         out_last
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int CRW   = 2 * DW + 1;
  localparam int NW    = (CRW > 31) ? CRW : 31;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = (XW + 1 > 11) ? XW + 1 : 11;
  localparam int AW    = $clog2(2 * MAX_WIDTH);
  localparam int DOTW  = 16 + CB + 2;
  localparam int NUMW  = DIV_STEPS;

  // frame position
  logic [10:0]   fw_r;
  logic [XW-1:0] col_r, dcol_r, x_r;
  logic          first_r, second_r, bank_r, drain_r, dup_r;
  // current item
  logic          act_r, pix_r, upok_r, last_r;
  logic signed [CB-1:0] p_r [3];
  logic signed [CB-1:0] c_r [3];
  logic signed [CB-1:0] l_r [3];
  logic signed [CB-1:0] rn_r [3];
  logic signed [CB-1:0] u_r [3];
  // arithmetic
  logic signed [63:0]    prod_r;
  logic signed [CRW-1:0] cr_r [3];
  logic [NW-1:0]         a_r [3];
  logic                  neg_r [3];
  logic                  degen_r;
  logic [63:0]           l2_r, sv_r, sres_r, sbit_r;
  logic [NUMW-1:0]       num_r, q_r;
  logic [32:0]           rem_r;
  logic signed [15:0]    nv_r [3];
  logic signed [DOTW-1:0] dot_r;
  // memory
  logic [3*CB-1:0] mem [2*MAX_WIDTH];
  logic [3*CB-1:0] rd_q_r;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            mem_we;

  logic [WW-1:0] w_eff, xp1;
  logic          row_end;
  logic signed [DW-1:0] g [3];
  logic signed [DW-1:0] h [3];
  logic signed [31:0] ma, mb;
  logic [NW-1:0] m;
  logic [31:0]   len;
  logic [32:0]   rem_sh;
  logic [63:0]   sq_t;
  logic [XW-1:0] xsel;
  logic [15:0]   qc;
  logic [1:0]    ci;

  function automatic logic [AW-1:0] addr_of(input logic bank, input logic [XW-1:0] col);
    addr_of = bank ? AW'(MAX_WIDTH) + AW'(col) : AW'(col);
  endfunction

  function automatic logic [XW-1:0] in_action_sel();
    in_action_sel = act_r ? (drain_r ? dcol_r : '0) : col_r;
  endfunction

  assign ci = cmd.idx[1:0];

  always_comb begin
    if (fw_r == 11'd0) w_eff = WW'(1);
    else if (WW'(fw_r) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fw_r);
    xp1 = WW'(x_r) + WW'(1);
    row_end = (xp1 >= w_eff);
    xsel = in_action_sel();
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g[i] = DW'(rn_r[i]) - DW'(l_r[i]);
      h[i] = (pix_r ? DW'(p_r[i]) : DW'(c_r[i])) - DW'(u_r[i]);
    end
    m = a_r[0];
    if (a_r[1] > m) m = a_r[1];
    if (a_r[2] > m) m = a_r[2];
    len    = sres_r[31:0];
    rem_sh = {rem_r[31:0], num_r[NUMW-1]};
    sq_t   = sres_r + sbit_r;
    qc     = (q_r > NUMW'(Q_ONE)) ? Q_ONE : q_r[15:0];
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL: begin
        case (cmd.idx)
          3'd0: begin ma = 32'(g[1]); mb = 32'(h[2]); end
          3'd1: begin ma = 32'(g[2]); mb = 32'(h[1]); end
          3'd2: begin ma = 32'(g[2]); mb = 32'(h[0]); end
          3'd3: begin ma = 32'(g[0]); mb = 32'(h[2]); end
          3'd4: begin ma = 32'(g[0]); mb = 32'(h[1]); end
          default: begin ma = 32'(g[1]); mb = 32'(h[0]); end
        endcase
      end
      OP_SQ: begin
        ma = signed'({2'b00, a_r[ci][29:0]});
        mb = signed'({2'b00, a_r[ci][29:0]});
      end
      OP_DOT: begin
        ma = 32'(nv_r[ci]);
        mb = 32'(c_r[ci]);
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_addr = addr_of(~bank_r, x_r);
    case (cmd.idx)
      3'd1: rd_addr = addr_of(~bank_r, (x_r == '0) ? x_r : x_r - XW'(1));
      3'd2: rd_addr = addr_of(~bank_r, row_end ? x_r : XW'(xp1));
      3'd3: rd_addr = addr_of(bank_r, x_r);
      default: ;
    endcase
    wr_addr = addr_of(bank_r, x_r);
    mem_we  = (cmd.op == OP_UPD) && pix_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {p_r[0], p_r[1], p_r[2]};
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    sts.out_busy = out_valid && !out_ready;
    sts.degen    = degen_r;
    sts.norm_ok  = ((m >> 29) == NW'(1));
    if (!act_r) sts.kind = drain_r ? KIND_IGNORE : (first_r ? KIND_STORE : KIND_NORMAL);
    else if (drain_r) sts.kind = KIND_NORMAL;
    else sts.kind = (col_r != '0 || first_r) ? KIND_IGNORE : KIND_NORMAL;
  end

  // frame position and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= FW_RESET;
      col_r    <= '0;
      dcol_r   <= '0;
      first_r  <= 1'b1;
      second_r <= 1'b0;
      bank_r   <= 1'b0;
      drain_r  <= 1'b0;
      dup_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) fw_r <= cfg_data;
      if (cmd.op == OP_DECIDE && act_r && !drain_r && sts.kind == KIND_NORMAL) begin
        drain_r <= 1'b1;
        dcol_r  <= '0;
        dup_r   <= !second_r;
      end
      if (cmd.op == OP_UPD) begin
        if (pix_r) begin
          if (row_end) begin
            col_r  <= '0;
            bank_r <= ~bank_r;
            if (first_r) begin
              first_r  <= 1'b0;
              second_r <= 1'b1;
            end else begin
              second_r <= 1'b0;
            end
          end else begin
            col_r <= XW'(xp1);
          end
        end else if (row_end) begin
          col_r    <= '0;
          first_r  <= 1'b1;
          second_r <= 1'b0;
          bank_r   <= 1'b0;
          drain_r  <= 1'b0;
          dcol_r   <= '0;
          dup_r    <= 1'b0;
        end else begin
          dcol_r <= XW'(xp1);
        end
      end
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r  <= in_action;
        p_r[0] <= in_px;
        p_r[1] <= in_py;
        p_r[2] <= in_pz;
      end
      OP_DECIDE: begin
        x_r    <= xsel;
        pix_r  <= !act_r;
        upok_r <= act_r ? (drain_r ? dup_r : !second_r) : !second_r;
        last_r <= act_r && ((WW'(xsel) + WW'(1)) >= w_eff);
      end
      OP_READ: begin
        for (int i = 0; i < 3; i++) begin
          case (cmd.idx)
            3'd1: c_r[i]  <= rd_q_r[(2-i)*CB +: CB];
            3'd2: l_r[i]  <= rd_q_r[(2-i)*CB +: CB];
            3'd3: rn_r[i] <= rd_q_r[(2-i)*CB +: CB];
            3'd4: u_r[i]  <= upok_r ? rd_q_r[(2-i)*CB +: CB] : c_r[i];
            default: ;
          endcase
        end
      end
      OP_MUL, OP_SQ, OP_DOT: prod_r <= ma * mb;
      OP_ACC: begin
        if (!cmd.idx[0]) cr_r[cmd.idx[2:1]] <= CRW'(prod_r);
        else cr_r[cmd.idx[2:1]] <= cr_r[cmd.idx[2:1]] - CRW'(prod_r);
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i]   <= NW'(cr_r[i][CRW-1] ? CRW'(-cr_r[i]) : CRW'(cr_r[i]));
          neg_r[i] <= cr_r[i][CRW-1];
          nv_r[i]  <= '0;
        end
        degen_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
        l2_r    <= '0;
        dot_r   <= '0;
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if ((m >> 30) != '0) a_r[i] <= a_r[i] >> 1;
          else a_r[i] <= a_r[i] << 1;
        end
      end
      OP_SQACC: l2_r <= l2_r + $unsigned(prod_r);
      OP_SQRTI: begin
        sv_r   <= l2_r;
        sres_r <= '0;
        sbit_r <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (sv_r >= sq_t) begin
          sv_r   <= sv_r - sq_t;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_DIVI: begin
        num_r <= (NUMW'(a_r[ci][29:0]) << FRAC_BITS) + NUMW'(len >> 1);
        rem_r <= '0;
        q_r   <= '0;
      end
      OP_DIV: begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, len}) begin
          rem_r <= rem_sh - {1'b0, len};
          q_r   <= {q_r[NUMW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[NUMW-2:0], 1'b0};
        end
      end
      OP_DIVE: nv_r[ci] <= neg_r[ci] ? -signed'(qc) : signed'(qc);
      OP_DOTACC: dot_r <= dot_r + DOTW'(prod_r);
      OP_FLIP: begin
        if (dot_r > 0) begin
          for (int i = 0; i < 3; i++) nv_r[i] <= -nv_r[i];
        end
      end
      OP_OUT: begin
        out_nx    <= nv_r[0];
        out_ny    <= nv_r[1];
        out_nz    <= nv_r[2];
        out_degen <= degen_r;
        out_last  <= last_r;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/dnest_ctrl.sv
// Controller: sequences one item through the datapath step by step.
// Issues dnest_cmd_t commands, reads dnest_sts_t status; uses dnest_pkg.
module dnest_ctrl
  import dnest_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dnest_sts_t sts,
  output dnest_cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_READ   = 5'd2;
  localparam logic [4:0] S_MUL    = 5'd3;
  localparam logic [4:0] S_ACC    = 5'd4;
  localparam logic [4:0] S_MAG    = 5'd5;
  localparam logic [4:0] S_NORM   = 5'd6;
  localparam logic [4:0] S_SQ     = 5'd7;
  localparam logic [4:0] S_SQACC  = 5'd8;
  localparam logic [4:0] S_SQRTI  = 5'd9;
  localparam logic [4:0] S_SQRT   = 5'd10;
  localparam logic [4:0] S_DIVI   = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_DIVE   = 5'd13;
  localparam logic [4:0] S_DOT    = 5'd14;
  localparam logic [4:0] S_DOTACC = 5'd15;
  localparam logic [4:0] S_FLIP   = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;
  localparam logic [4:0] S_UPD    = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;

  // no transfer is taken while reset is held
  assign in_ready = (state_r == S_IDLE) && rst_n;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r[2:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.op  = OP_DECIDE;
        cnt_nxt = '0;
        case (sts.kind)
          KIND_STORE:  state_nxt = S_UPD;
          KIND_NORMAL: state_nxt = S_READ;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_READ: begin
        cmd.op = OP_READ;
        if (cnt_r == 6'(READ_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (cnt_r == 6'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MAG;
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_MUL;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // a zero cross product goes straight to the result
        if (sts.degen) state_nxt = S_OUT;
        else if (sts.norm_ok) state_nxt = S_SQ;
        else cmd.op = OP_NORM;
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = OP_SQACC;
        if (cnt_r == 6'd2) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRTI;
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_SQ;
        end
      end
      S_SQRTI: begin
        cmd.op    = OP_SQRTI;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          comp_nxt  = '0;
          state_nxt = S_DIVI;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIVI;
        cmd.idx   = {1'b0, comp_r};
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = S_DIVE;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_DIVE: begin
        cmd.op  = OP_DIVE;
        cmd.idx = {1'b0, comp_r};
        cnt_nxt = '0;
        if (comp_r == 2'd2) state_nxt = S_DOT;
        else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_DOT: begin
        cmd.op    = OP_DOT;
        state_nxt = S_DOTACC;
      end
      S_DOTACC: begin
        cmd.op = OP_DOTACC;
        if (cnt_r == 6'd2) state_nxt = S_FLIP;
        else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_DOT;
        end
      end
      S_FLIP: begin
        cmd.op    = OP_FLIP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

  a_take_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DEC))
    else $error("accepted item not decoded");

  a_out_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !sts.out_busy) |=> (state_r == S_UPD))
    else $error("result load not followed by update");

  a_norm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM && sts.norm_ok && !sts.degen) |=> (state_r == S_SQ))
    else $error("normalised vector not squared");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < 6'(DIV_STEPS)))
    else $error("step counter out of range");

endmodule

>>> test/tb.sv
// Testbench of depth_image_normal_estimator: raster frames of points in, unit normals out.
// Needs dnest_pkg, the dnest_if interfaces and the RTL. Results are checked against an
// in-bench model of line stores, cross product and normalisation, or a directed want.
`timescale 1ns / 100ps

module tb
  import dnest_pkg::*;
();

  localparam int MAXW = 1024;
  localparam int SETTLE_CYCLES = 320;

  typedef enum logic {ACT_PIXEL = 1'b0, ACT_DRAIN = 1'b1} act_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
    logic               last;
  } normal_t;

  typedef struct {
    act_t        act;
    shortint     px;
    shortint     py;
    shortint     pz;
    bit          typed;
    normal_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dnest_in_if #(.COORD_BITS(16)) in_ch ();
  dnest_out_if out_ch ();
  dnest_cfg_if cfg_ch ();

  depth_image_normal_estimator #(.MAX_WIDTH(MAXW), .COORD_BITS(16)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  point_t      rows_mem [0:2*MAXW-1];
  int unsigned col_cnt;
  bit          first_row;
  bit          second_row;
  int unsigned wbank;
  bit          draining;
  int unsigned drain_col;
  bit          drain_up;
  int unsigned frame_w;

  normal_t normal_q[$];
  int      errors = 0;
  int      n_results = 0;
  int      n_degen = 0;
  int      n_last = 0;
  int      n_effective = 0;
  int      n_flipped = 0;
  int      send_idle = 0;
  int      recv_idle = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t surface_normal(point_t l, point_t r, point_t u, point_t d,
                                             point_t c, bit last);
    longint          gx, gy, gz, hx, hy, hz;
    longint          cr [3];
    longint          nv [3];
    longint unsigned a [3];
    longint unsigned m, l2, len, q;
    int              rs, ls;
    normal_t         o;
    gx = r.x - l.x; gy = r.y - l.y; gz = r.z - l.z;
    hx = d.x - u.x; hy = d.y - u.y; hz = d.z - u.z;
    cr[0] = gy * hz - gz * hy;
    cr[1] = gz * hx - gx * hz;
    cr[2] = gx * hy - gy * hx;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = cr[i] < 0 ? -cr[i] : cr[i];
      nv[i] = 0;
      if (a[i] > m) m = a[i];
    end
    o.degen = (m == 0);
    if (m != 0) begin
      rs = 0;
      ls = 0;
      l2 = 0;
      while ((m >> rs) >= (64'd1 << 30)) rs++;
      while (((m >> rs) << ls) < (64'd1 << 29)) ls++;
      for (int i = 0; i < 3; i++) begin
        a[i] = (a[i] >> rs) << ls;
        l2 += a[i] * a[i];
      end
      len = isqrt(l2);
      for (int i = 0; i < 3; i++) begin
        q = (a[i] * 16384 + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        nv[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
      end
      // orient towards the camera
      if (nv[0] * c.x + nv[1] * c.y + nv[2] * c.z > 0) begin
        for (int i = 0; i < 3; i++) nv[i] = -nv[i];
        n_flipped++;
      end
    end
    o.nx = nv[0][15:0];
    o.ny = nv[1][15:0];
    o.nz = nv[2][15:0];
    o.last = last;
    return o;
  endfunction

  function automatic void start_frame();
    col_cnt = 0;
    first_row = 1'b1;
    second_row = 1'b0;
    wbank = 0;
    draining = 1'b0;
    drain_col = 0;
    drain_up = 1'b0;
  endfunction

  // advance the model by one accepted item; returns 1 when a normal is due
  function automatic bit predict_normal(act_t act, shortint px, shortint py, shortint pz,
                                        output normal_t o, output bit effective);
    int unsigned w, cb, ub, x;
    point_t      p, c, l, r, u;
    bit          due;
    w = frame_w < 1 ? 1 : (frame_w > MAXW ? MAXW : frame_w);
    cb = (wbank ^ 1) * MAXW;
    ub = wbank * MAXW;
    due = 1'b0;
    effective = 1'b0;
    o = '{default: '0};
    if (act == ACT_PIXEL) begin
      if (draining) return 1'b0;
      effective = 1'b1;
      p.x = px; p.y = py; p.z = pz;
      x = col_cnt % MAXW;
      if (!first_row) begin
        c = rows_mem[cb + x];
        l = x > 0 ? rows_mem[cb + x - 1] : c;
        r = (x + 1 < w) ? rows_mem[cb + x + 1] : c;
        u = second_row ? c : rows_mem[ub + x];
        o = surface_normal(l, r, u, p, c, 1'b0);
        due = 1'b1;
      end
      rows_mem[ub + x] = p;
      if (x + 1 >= w) begin
        col_cnt = 0;
        wbank ^= 1;
        second_row = first_row;
        first_row = 1'b0;
      end else begin
        col_cnt = x + 1;
      end
      return due;
    end
    if (!draining) begin
      if (col_cnt != 0 || first_row) return 1'b0;
      draining = 1'b1;
      drain_col = 0;
      drain_up = !second_row;
    end
    effective = 1'b1;
    x = drain_col % MAXW;
    c = rows_mem[cb + x];
    l = x > 0 ? rows_mem[cb + x - 1] : c;
    r = (x + 1 < w) ? rows_mem[cb + x + 1] : c;
    u = drain_up ? rows_mem[ub + x] : c;
    if (x + 1 >= w) begin
      o = surface_normal(l, r, u, c, c, 1'b1);
      start_frame();
    end else begin
      o = surface_normal(l, r, u, c, c, 1'b0);
      drain_col = x + 1;
    end
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(act_t act, shortint px, shortint py, shortint pz,
                           bit typed = 1'b0, normal_t want = '{default: '0});
    normal_t o;
    bit      due;
    bit      eff;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.point_x = px;
    in_ch.point_y = py;
    in_ch.point_z = pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    due = predict_normal(act, px, py, pz, o, eff);
    if (eff) n_effective++;
    if (due) normal_q.push_back(typed ? want : o);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (normal_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(logic [10:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    frame_w = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // result side: ready set at the falling edge, transfer seen at the rising edge
  initial begin
    normal_t e;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_idle);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.degenerate) n_degen++;
        if (out_ch.frame_last) n_last++;
        if (normal_q.size() == 0) begin
          $error("normal with none expected: %0d %0d %0d", out_ch.normal_x,
                 out_ch.normal_y, out_ch.normal_z);
          errors++;
        end else begin
          e = normal_q.pop_front();
          if (out_ch.normal_x !== e.nx) begin
            $error("normal_x: expected %0d, got %0d", e.nx, out_ch.normal_x);
            errors++;
          end
          if (out_ch.normal_y !== e.ny) begin
            $error("normal_y: expected %0d, got %0d", e.ny, out_ch.normal_y);
            errors++;
          end
          if (out_ch.normal_z !== e.nz) begin
            $error("normal_z: expected %0d, got %0d", e.nz, out_ch.normal_z);
            errors++;
          end
          if (out_ch.degenerate !== e.degen) begin
            $error("degenerate: expected %0b, got %0b", e.degen, out_ch.degenerate);
            errors++;
          end
          if (out_ch.frame_last !== e.last) begin
            $error("frame_last: expected %0b, got %0b", e.last, out_ch.frame_last);
            errors++;
          end
        end
      end
    end
  end

  function automatic shortint pick_coord(int mode, int axis, int row, int col, int s,
                                         int base);
    shortint ext [4] = '{-32768, 32767, 0, -1};
    case (mode)
      0: begin
        case (axis)
          0: return shortint'((col - 2) * s + $urandom_range(3));
          1: return shortint'((row - 2) * s + $urandom_range(3));
          default: return shortint'(base + col * (s / 3) - row * (s / 5)
                                    + $urandom_range(7));
        endcase
      end
      1: return shortint'($urandom);
      2: return shortint'(base);
      default: return ext[$urandom_range(3)];
    endcase
  endfunction

  task automatic random_frame();
    int      sel, w, rows, total, sent, row, col, mode, s, base;
    sel = $urandom_range(99);
    rows = $urandom_range(1, 4);
    mode = $urandom_range(99) < 55 ? 0 : $urandom_range(1, 3);
    s = $urandom_range(1, 400);
    base = $urandom_range(0, 1) ? $urandom_range(200, 6000) : -$urandom_range(0, 6000);
    sent = 0;
    if (sel < 4) begin
      write_width(11'd0);
    end else if (sel < 8) begin
      // widest rows: start the first row long, then narrow it to four pixels
      write_width(sel < 6 ? 11'd1024 : 11'd2047);
      repeat (3) begin
        send_item(ACT_PIXEL, shortint'($urandom), shortint'($urandom), shortint'($urandom));
        sent++;
      end
      settle();
      write_width(11'd4);
    end else begin
      write_width(11'($urandom_range(1, 8)));
    end
    w = frame_w < 1 ? 1 : frame_w;
    total = rows * w;
    for (int i = sent; i < total; i++) begin
      row = i / w;
      col = i % w;
      if ($urandom_range(99) < 4)
        send_item(ACT_DRAIN, shortint'($urandom), shortint'($urandom), shortint'($urandom));
      send_item(ACT_PIXEL, pick_coord(mode, 0, row, col, s, base),
                pick_coord(mode, 1, row, col, s, base), pick_coord(mode, 2, row, col, s, base));
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(99) < 3)
        send_item(ACT_PIXEL, shortint'($urandom), shortint'($urandom), shortint'($urandom));
      send_item(ACT_DRAIN, 16'sd0, 16'sd0, 16'sd0);
    end
    // stray drains may have split the frame: bring it back to a clean start
    while (draining || col_cnt != 0 || !first_row) begin
      if (!draining && col_cnt != 0)
        send_item(ACT_PIXEL, shortint'($urandom), shortint'($urandom), shortint'($urandom));
      else
        send_item(ACT_DRAIN, 16'sd0, 16'sd0, 16'sd0);
    end
    settle();
  endtask

  stim_row_t directed [$];

  initial begin
    normal_t   flat, none, degen0;
    int        phase_items;
    flat = '{nx: 16'sd0, ny: 16'sd0, nz: -16'sd16384, degen: 1'b0, last: 1'b0};
    degen0 = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, degen: 1'b1, last: 1'b0};
    none = '{default: '0};
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PIXEL;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < 2 * MAXW; i++) rows_mem[i] = '{0, 0, 0};
    frame_w = FW_RESET;
    start_frame();

    // flat plane at z = 100, drains that are ignored, pixel during a drain
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 0, 0, 100, 1'b0, none});
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 10, 0, 100, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 20, 0, 100, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 0, 10, 100, 1'b1, flat});
    directed.push_back('{ACT_PIXEL, 10, 10, 100, 1'b1, flat});
    directed.push_back('{ACT_PIXEL, 20, 10, 100, 1'b1, flat});
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, flat});
    directed.push_back('{ACT_PIXEL, 5, 5, 5, 1'b0, none});
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, flat});
    flat.last = 1'b1;
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, flat});
    // single row of points at the origin: degenerate
    repeat (3) directed.push_back('{ACT_PIXEL, 0, 0, 0, 1'b0, none});
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, degen0});
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, degen0});
    degen0.last = 1'b1;
    directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b1, degen0});
    // coordinate extremes
    directed.push_back('{ACT_PIXEL, -32768, 32767, -32768, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 32767, -32768, 32767, 1'b0, none});
    directed.push_back('{ACT_PIXEL, -1, 0, 32767, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 32767, 32767, -32768, 1'b0, none});
    directed.push_back('{ACT_PIXEL, -32768, -32768, 1, 1'b0, none});
    directed.push_back('{ACT_PIXEL, 0, -1, -32768, 1'b0, none});
    repeat (3) directed.push_back('{ACT_DRAIN, 0, 0, 0, 1'b0, none});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_width(11'd3);
    foreach (directed[i])
      send_item(directed[i].act, directed[i].px, directed[i].py, directed[i].pz,
                directed[i].typed, directed[i].want);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 30 : (ph == 1 ? 65 : 0);
      recv_idle = ph == 0 ? 65 : (ph == 1 ? 30 : 0);
      phase_items = n_effective;
      while (n_effective - phase_items < 370) random_frame();
    end
    write_width(FW_RESET);
    settle();

    $display("%0d items, %0d normals (%0d degenerate, %0d flipped, %0d frame ends)",
             n_effective, n_results, n_degen, n_flipped, n_last);
    $display("widths 0 to 2047, three idling mixes, stray drains and pixels");
    if (errors == 0 && normal_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (normal_q.size() != 0) $error("%0d normals never arrived", normal_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
